// ===== hdl/cqs_pkg.sv =====
// Package for the circle versus convex quadrilateral separation test.
// Holds the request and result types, pipeline types and shared constants.
// No dependencies.
package cqs_pkg;

    localparam int COORD_W = 16;
    localparam int RAD_W   = COORD_W - 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int FRAC_W  = 4;
    localparam int TOL_W   = 8;
    localparam int T_FRAC  = 30;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DOT_W   = 2 * COORD_W + 3;
    localparam int REM_W   = SQ_W + 1;
    localparam int D2_W    = 2 * COORD_W + 5;
    localparam int RR_W    = 2 * COORD_W;
    localparam int SEG_LAT = T_FRAC + 5;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CD = 2'd2;
    localparam logic [1:0] EDGE_DA = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] quad_ax;
        logic signed [COORD_W-1:0] quad_ay;
        logic signed [COORD_W-1:0] quad_bx;
        logic signed [COORD_W-1:0] quad_by;
        logic signed [COORD_W-1:0] quad_cx;
        logic signed [COORD_W-1:0] quad_cy;
        logic signed [COORD_W-1:0] quad_dx;
        logic signed [COORD_W-1:0] quad_dy;
        logic signed [COORD_W-1:0] circle_x;
        logic signed [COORD_W-1:0] circle_y;
        logic [RAD_W-1:0]          circle_radius;
        logic                      tangent_ok;
    } query_t;

    typedef struct packed {
        logic       is_outside;
        logic       edge_reported;
        logic [1:0] nearest_edge;
    } result_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] abx;
        logic signed [DIFF_W-1:0] aby;
        logic signed [DIFF_W-1:0] apx;
        logic signed [DIFF_W-1:0] apy;
        logic [SQ_W-1:0]          ab2;
        logic signed [DOT_W-1:0]  dot;
        logic [SQ_W-1:0]          ap2;
    } seg_in_t;

    typedef struct packed {
        logic [SQ_W-1:0]          ab2;
        logic [REM_W-1:0]         rem;
        logic [T_FRAC-1:0]        q;
        logic                     full;
        logic                     zero;
        logic signed [DIFF_W-1:0] abx;
        logic signed [DIFF_W-1:0] aby;
        logic signed [DIFF_W-1:0] apx;
        logic signed [DIFF_W-1:0] apy;
        logic [SQ_W-1:0]          ap2;
    } div_t;

    typedef struct packed {
        logic            in_quad;
        logic            tangent;
        logic            rlo_pos;
        logic [RR_W-1:0] lo2;
        logic [RR_W-1:0] hi2;
    } common_t;

endpackage

// ===== hdl/cqs_seg_dist.sv =====
// Squared point-to-segment distance for one edge, fully pipelined.
// Uses a restoring divider with one quotient bit per stage for the segment parameter.
// Depends on cqs_pkg.
module cqs_seg_dist (
    input  logic                      clk,
    input  logic                      en,
    input  cqs_pkg::seg_in_t          seg,
    output logic [cqs_pkg::D2_W-1:0]  d2
);
    import cqs_pkg::*;

    div_t dv_reg [0:T_FRAC];
    div_t dv_next [1:T_FRAC];

    logic                      full_c;
    logic                      mid_c;
    logic signed [DOT_W-1:0]   ab2_s;

    logic [T_FRAC:0]                 t_c;
    logic signed [2*DIFF_W+T_FRAC:0] mx_reg, my_reg;
    logic signed [DIFF_W-1:0]        apx_m_reg, apy_m_reg;
    logic                            zero_m_reg;
    logic [SQ_W-1:0]                 ap2_m_reg;

    logic signed [DIFF_W+1:0] offx_c, offy_c;
    logic signed [DIFF_W+1:0] dx_reg, dy_reg;
    logic                     zero_d_reg;
    logic [SQ_W-1:0]          ap2_d_reg;

    logic signed [2*DIFF_W+3:0] sqx_c, sqy_c;
    logic [D2_W-2:0]            sqx_reg, sqy_reg;
    logic                       zero_s_reg;
    logic [SQ_W-1:0]            ap2_s_reg;

    logic [D2_W-1:0] d2_reg;

    always_comb
    begin
        ab2_s  = $signed({2'b00, seg.ab2});
        full_c = (seg.dot > 0) && (seg.dot >= ab2_s);
        mid_c  = (seg.dot > 0) && (seg.dot < ab2_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].ab2  <= seg.ab2;
            dv_reg[0].rem  <= mid_c ? seg.dot[REM_W-1:0] : '0;
            dv_reg[0].q    <= '0;
            dv_reg[0].full <= full_c;
            dv_reg[0].zero <= (seg.ab2 == '0);
            dv_reg[0].abx  <= seg.abx;
            dv_reg[0].aby  <= seg.aby;
            dv_reg[0].apx  <= seg.apx;
            dv_reg[0].apy  <= seg.apy;
            dv_reg[0].ap2  <= seg.ap2;
        end
    end

    genvar i;
    generate
        for (i = 1; i <= T_FRAC; i++)
        begin : g_div
            logic [REM_W-1:0] rem2;
            logic             ge;

            always_comb
            begin
                rem2 = {dv_reg[i-1].rem[REM_W-2:0], 1'b0};
                ge   = (rem2 >= {1'b0, dv_reg[i-1].ab2});
                dv_next[i]     = dv_reg[i-1];
                dv_next[i].rem = ge ? (rem2 - {1'b0, dv_reg[i-1].ab2}) : rem2;
                dv_next[i].q   = {dv_reg[i-1].q[T_FRAC-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_reg[i] <= dv_next[i];
                end
            end
        end
    endgenerate

    assign t_c = dv_reg[T_FRAC].full ? {1'b1, {T_FRAC{1'b0}}} : {1'b0, dv_reg[T_FRAC].q};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg     <= dv_reg[T_FRAC].abx * $signed({1'b0, t_c});
            my_reg     <= dv_reg[T_FRAC].aby * $signed({1'b0, t_c});
            apx_m_reg  <= dv_reg[T_FRAC].apx;
            apy_m_reg  <= dv_reg[T_FRAC].apy;
            zero_m_reg <= dv_reg[T_FRAC].zero;
            ap2_m_reg  <= dv_reg[T_FRAC].ap2;
        end
    end

    always_comb
    begin
        offx_c = mx_reg[T_FRAC+DIFF_W+1:T_FRAC];
        offy_c = my_reg[T_FRAC+DIFF_W+1:T_FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= {{2{apx_m_reg[DIFF_W-1]}}, apx_m_reg} - offx_c;
            dy_reg     <= {{2{apy_m_reg[DIFF_W-1]}}, apy_m_reg} - offy_c;
            zero_d_reg <= zero_m_reg;
            ap2_d_reg  <= ap2_m_reg;
        end
    end

    always_comb
    begin
        sqx_c = dx_reg * dx_reg;
        sqy_c = dy_reg * dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= sqx_c[D2_W-2:0];
            sqy_reg    <= sqy_c[D2_W-2:0];
            zero_s_reg <= zero_d_reg;
            ap2_s_reg  <= ap2_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg <= zero_s_reg ? D2_W'(ap2_s_reg)
                                 : ({1'b0, sqx_reg} + {1'b0, sqy_reg});
        end
    end

    assign d2 = d2_reg;

endmodule

// ===== hdl/circle_quad_separation_test.sv =====
// Top level of the circle versus convex quadrilateral separation test.
// Front end (winding, half-planes, segment terms), four distance pipelines, selection.
// Depends on cqs_pkg and cqs_seg_dist.
//
//   channel | signals                          | carries
//   query   | query_valid, query_ready, query  | one request: quadrilateral and circle
//   result  | result_valid, result_ready, result | one result per request
//   cfg     | cfg_valid, cfg_ready, cfg_data   | tolerance register write
//
// One request is taken every cycle while no result is stalled; the segment parameter
// of each edge is formed by a 30-stage restoring divider.
// Reset clears the valid bits and sets the tolerance to one.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module circle_quad_separation_test (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       query_valid,
    output logic                       query_ready,
    input  cqs_pkg::query_t            query,
    output logic                       result_valid,
    input  logic                       result_ready,
    output cqs_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cqs_pkg::TOL_W-1:0]  cfg_data
);
    import cqs_pkg::*;

    logic             en;
    logic [TOL_W-1:0] tol_reg;

    logic signed [COORD_W-1:0] vx [4];
    logic signed [COORD_W-1:0] vy [4];

    logic signed [DIFF_W-1:0] abx1_reg [4], aby1_reg [4], apx1_reg [4], apy1_reg [4];
    logic signed [RR_W-1:0]   arp1_reg [4], arn1_reg [4];
    logic signed [COORD_W-1:0] rlo1_reg;
    logic [COORD_W-1:0]        rhi1_reg;
    logic                      tan1_reg;
    logic                      v1_reg;

    logic signed [SQ_W:0]      cra2_reg [4], crb2_reg [4];
    logic signed [SQ_W:0]      abxx2_reg [4], abyy2_reg [4];
    logic signed [SQ_W:0]      dtx2_reg [4], dty2_reg [4];
    logic signed [SQ_W:0]      apxx2_reg [4], apyy2_reg [4];
    logic signed [DIFF_W-1:0]  abx2_reg [4], aby2_reg [4], apx2_reg [4], apy2_reg [4];
    logic signed [DOT_W-1:0]   area_c;
    logic signed [DOT_W-1:0]   area2_reg;
    logic [RR_W-1:0]           lo2_2_reg, hi2_2_reg;
    logic                      rpos2_reg, tan2_reg, v2_reg;

    logic signed [SQ_W+2:0]    cross_c [4];
    logic signed [SQ_W+2:0]    lim_c;
    logic [3:0]                ok_c;
    seg_in_t                   seg3_reg [4];
    common_t                   cm3_reg;
    logic                      v3_reg;

    logic [D2_W-1:0] d2_w [4];
    common_t         cm_reg [0:SEG_LAT-1];
    logic            vl_reg [0:SEG_LAT-1];

    logic [D2_W-1:0] m01_c, m23_c, best_c;
    logic [1:0]      k01_c, k23_c, kbest_c;
    logic [D2_W-1:0] best4_reg;
    logic [1:0]      k4_reg;
    common_t         cm4_reg;
    logic            v4_reg;

    result_t result_next, result_reg;
    logic    result_valid_reg;

    assign en          = !result_valid_reg || result_ready;
    assign query_ready = en;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    always_comb
    begin
        vx[0] = query.quad_ax;  vy[0] = query.quad_ay;
        vx[1] = query.quad_bx;  vy[1] = query.quad_by;
        vx[2] = query.quad_cx;  vy[2] = query.quad_cy;
        vx[3] = query.quad_dx;  vy[3] = query.quad_dy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                abx1_reg[k] <= DIFF_W'(vx[(k+1)%4]) - DIFF_W'(vx[k]);
                aby1_reg[k] <= DIFF_W'(vy[(k+1)%4]) - DIFF_W'(vy[k]);
                apx1_reg[k] <= DIFF_W'(query.circle_x) - DIFF_W'(vx[k]);
                apy1_reg[k] <= DIFF_W'(query.circle_y) - DIFF_W'(vy[k]);
                arp1_reg[k] <= vx[k] * vy[(k+1)%4];
                arn1_reg[k] <= vx[(k+1)%4] * vy[k];
            end
            rlo1_reg <= $signed({1'b0, query.circle_radius})
                        - $signed({{(COORD_W-TOL_W){1'b0}}, tol_reg});
            rhi1_reg <= {1'b0, query.circle_radius} + {{(COORD_W-TOL_W){1'b0}}, tol_reg};
            tan1_reg <= query.tangent_ok;
        end
    end

    always_comb
    begin
        area_c = '0;
        for (int k = 0; k < 4; k++)
        begin
            area_c = area_c + DOT_W'(arp1_reg[k]) - DOT_W'(arn1_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cra2_reg[k]  <= abx1_reg[k] * apy1_reg[k];
                crb2_reg[k]  <= aby1_reg[k] * apx1_reg[k];
                abxx2_reg[k] <= abx1_reg[k] * abx1_reg[k];
                abyy2_reg[k] <= aby1_reg[k] * aby1_reg[k];
                dtx2_reg[k]  <= apx1_reg[k] * abx1_reg[k];
                dty2_reg[k]  <= apy1_reg[k] * aby1_reg[k];
                apxx2_reg[k] <= apx1_reg[k] * apx1_reg[k];
                apyy2_reg[k] <= apy1_reg[k] * apy1_reg[k];
                abx2_reg[k]  <= abx1_reg[k];
                aby2_reg[k]  <= aby1_reg[k];
                apx2_reg[k]  <= apx1_reg[k];
                apy2_reg[k]  <= apy1_reg[k];
            end
            area2_reg <= area_c;
            lo2_2_reg <= RR_W'(rlo1_reg * rlo1_reg);
            hi2_2_reg <= rhi1_reg * rhi1_reg;
            rpos2_reg <= (rlo1_reg > 0);
            tan2_reg  <= tan1_reg;
        end
    end

    always_comb
    begin
        lim_c = -$signed({{(SQ_W+3-TOL_W-FRAC_W){1'b0}}, tol_reg, {FRAC_W{1'b0}}});
        for (int k = 0; k < 4; k++)
        begin
            cross_c[k] = (SQ_W+3)'(cra2_reg[k]) - (SQ_W+3)'(crb2_reg[k]);
            if (area2_reg < 0)
            begin
                cross_c[k] = -cross_c[k];
            end
            ok_c[k] = (cross_c[k] >= lim_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                seg3_reg[k].abx <= abx2_reg[k];
                seg3_reg[k].aby <= aby2_reg[k];
                seg3_reg[k].apx <= apx2_reg[k];
                seg3_reg[k].apy <= apy2_reg[k];
                seg3_reg[k].ab2 <= SQ_W'(abxx2_reg[k]) + SQ_W'(abyy2_reg[k]);
                seg3_reg[k].dot <= DOT_W'(dtx2_reg[k]) + DOT_W'(dty2_reg[k]);
                seg3_reg[k].ap2 <= SQ_W'(apxx2_reg[k]) + SQ_W'(apyy2_reg[k]);
            end
            cm3_reg.in_quad <= &ok_c;
            cm3_reg.tangent <= tan2_reg;
            cm3_reg.rlo_pos <= rpos2_reg;
            cm3_reg.lo2     <= lo2_2_reg;
            cm3_reg.hi2     <= hi2_2_reg;
        end
    end

    genvar e;
    generate
        for (e = 0; e < 4; e++)
        begin : g_edge
            cqs_seg_dist u_seg (
                .clk (clk),
                .en  (en),
                .seg (seg3_reg[e]),
                .d2  (d2_w[e])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg[0] <= cm3_reg;
            for (int s = 1; s < SEG_LAT; s++)
            begin
                cm_reg[s] <= cm_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (d2_w[1] < d2_w[0])
        begin
            m01_c = d2_w[1];  k01_c = EDGE_BC;
        end
        else
        begin
            m01_c = d2_w[0];  k01_c = EDGE_AB;
        end
        if (d2_w[3] < d2_w[2])
        begin
            m23_c = d2_w[3];  k23_c = EDGE_DA;
        end
        else
        begin
            m23_c = d2_w[2];  k23_c = EDGE_CD;
        end
        if (m23_c < m01_c)
        begin
            best_c = m23_c;  kbest_c = k23_c;
        end
        else
        begin
            best_c = m01_c;  kbest_c = k01_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best4_reg <= best_c;
            k4_reg    <= kbest_c;
            cm4_reg   <= cm_reg[SEG_LAT-1];
        end
    end

    always_comb
    begin
        result_next = '0;
        if (!cm4_reg.in_quad)
        begin
            if (cm4_reg.tangent)
            begin
                result_next.is_outside = !cm4_reg.rlo_pos
                                         || (best4_reg >= D2_W'(cm4_reg.lo2));
            end
            else if (best4_reg > D2_W'(cm4_reg.hi2))
            begin
                result_next.is_outside = 1'b1;
            end
            else
            begin
                result_next.edge_reported = 1'b1;
                result_next.nearest_edge  = k4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int s = 0; s < SEG_LAT; s++)
            begin
                vl_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= query_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vl_reg[0] <= v3_reg;
            for (int s = 1; s < SEG_LAT; s++)
            begin
                vl_reg[s] <= vl_reg[s-1];
            end
            v4_reg           <= vl_reg[SEG_LAT-1];
            result_valid_reg <= v4_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_edge_not_outside : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.edge_reported |-> !result.is_outside)
        else $error("edge reported on a separated circle");

    a_edge_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.edge_reported |-> result.nearest_edge == EDGE_AB)
        else $error("nearest edge set without contact");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && result_valid && !result_ready |=> v4_reg && $stable(best4_reg))
        else $error("selection stage moved during a stall");

endmodule

// ===== verif/tb_circle_quad_separation_test.sv =====
// Testbench for circle_quad_separation_test: directed and random geometry requests
// checked against a bit-exact predictor of the separation test. Depends on cqs_pkg.
`timescale 1ns / 1ps
module tb_circle_quad_separation_test;
    import cqs_pkg::*;

    localparam int LATENCY = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic query_valid = 1'b0;
    logic query_ready;
    query_t query = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;

    query_t pending_q[$];
    result_t expected_q[$];
    logic [TOL_W-1:0] tol_model;
    int errors = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 46;
    int hold_cycles = 0;
    bit stim_done = 1'b0;

    always #1 clk = ~clk;

    circle_quad_separation_test i_dut (
        .clk(clk), .rst_n(rst_n),
        .query_valid(query_valid), .query_ready(query_ready), .query(query),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic logic signed [127:0] seg_dist_sq(
        input logic signed [127:0] px, py, ax, ay, bx, by);
        logic signed [127:0] abx, aby, apx, apy, ab2, dot, rem, t, dx, dy;
        begin
            abx = bx - ax;
            aby = by - ay;
            apx = px - ax;
            apy = py - ay;
            ab2 = abx * abx + aby * aby;
            if (ab2 == 0)
                return apx * apx + apy * apy;
            dot = apx * abx + apy * aby;
            t = 0;
            if (dot <= 0)
                t = 0;
            else if (dot >= ab2)
                t = 128'sd1 <<< T_FRAC;
            else
            begin
                rem = dot;
                for (int i = 0; i < T_FRAC; i++)
                begin
                    rem = rem <<< 1;
                    t = t <<< 1;
                    if (rem >= ab2)
                    begin
                        rem = rem - ab2;
                        t = t + 1;
                    end
                end
            end
            dx = apx - ((abx * t) >>> T_FRAC);
            dy = apy - ((aby * t) >>> T_FRAC);
            return dx * dx + dy * dy;
        end
    endfunction

    function automatic result_t predict_separation(input query_t q, input logic [TOL_W-1:0] tol);
        logic signed [127:0] vx[4], vy[4], px, py, r, eps, area, cr, best, d2, lim;
        result_t res;
        bit ccw, in_quad;
        logic [1:0] best_k;
        int n;
        begin
            vx[0] = q.quad_ax; vy[0] = q.quad_ay;
            vx[1] = q.quad_bx; vy[1] = q.quad_by;
            vx[2] = q.quad_cx; vy[2] = q.quad_cy;
            vx[3] = q.quad_dx; vy[3] = q.quad_dy;
            px = q.circle_x;
            py = q.circle_y;
            r = {113'd0, q.circle_radius};
            eps = {120'd0, tol};
            lim = eps <<< FRAC_W;
            res = '0;
            area = 0;
            for (int k = 0; k < 4; k++)
            begin
                n = (k + 1) % 4;
                area = area + vx[k] * vy[n] - vx[n] * vy[k];
            end
            ccw = (area >= 0);
            in_quad = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                n = (k + 1) % 4;
                cr = (vx[n] - vx[k]) * (py - vy[k]) - (vy[n] - vy[k]) * (px - vx[k]);
                if (!ccw)
                    cr = -cr;
                if (cr < -lim)
                    in_quad = 1'b0;
            end
            if (in_quad)
                return res;
            best = seg_dist_sq(px, py, vx[0], vy[0], vx[1], vy[1]);
            best_k = EDGE_AB;
            for (int k = 1; k < 4; k++)
            begin
                n = (k + 1) % 4;
                d2 = seg_dist_sq(px, py, vx[k], vy[k], vx[n], vy[n]);
                if (d2 < best)
                begin
                    best = d2;
                    best_k = 2'(k);
                end
            end
            if (q.tangent_ok)
                res.is_outside = ((r - eps) <= 0) || (best >= (r - eps) * (r - eps));
            else if (best > (r + eps) * (r + eps))
                res.is_outside = 1'b1;
            else
            begin
                res.edge_reported = 1'b1;
                res.nearest_edge = best_k;
            end
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (query_valid && query_ready)
            expected_q.push_back(predict_separation(query, tol_model));
        if (!query_valid || query_ready)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                query <= pending_q.pop_front();
                query_valid <= 1'b1;
            end
            else
                query_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (result.is_outside !== want.is_outside)
                    report_mismatch("is_outside", result.is_outside, want.is_outside);
                if (result.edge_reported !== want.edge_reported)
                    report_mismatch("edge_reported", result.edge_reported, want.edge_reported);
                if (result.nearest_edge !== want.nearest_edge)
                    report_mismatch("nearest_edge", result.nearest_edge, want.nearest_edge);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
        return COORD_W'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic query_t random_query();
        query_t q;
        logic signed [COORD_W-1:0] cx, cy, s;
        logic [191:0] raw;
        int mode;
        begin
            mode = $urandom_range(9);
            q.tangent_ok = $urandom_range(1);
            if (mode < 2)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                q = raw[$bits(query_t)-1:0];
            end
            else
            begin
                cx = rand_coord(8000);
                cy = rand_coord(8000);
                s = COORD_W'($urandom_range(mode < 5 ? 60 : 3000));
                q.quad_ax = cx - s + rand_coord(s / 4 + 1);
                q.quad_ay = cy - s + rand_coord(s / 4 + 1);
                q.quad_bx = cx + s + rand_coord(s / 4 + 1);
                q.quad_by = cy - s + rand_coord(s / 4 + 1);
                q.quad_cx = cx + s + rand_coord(s / 4 + 1);
                q.quad_cy = cy + s + rand_coord(s / 4 + 1);
                q.quad_dx = cx - s + rand_coord(s / 4 + 1);
                q.quad_dy = cy + s + rand_coord(s / 4 + 1);
                if ($urandom_range(1))
                begin
                    {q.quad_bx, q.quad_by, q.quad_dx, q.quad_dy} =
                        {q.quad_dx, q.quad_dy, q.quad_bx, q.quad_by};
                end
                if ($urandom_range(7) == 0)
                    {q.quad_cx, q.quad_cy} = {q.quad_bx, q.quad_by};
                q.circle_x = cx + rand_coord(2 * s + 20);
                q.circle_y = cy + rand_coord(2 * s + 20);
                q.circle_radius = RAD_W'($urandom_range(2 * s + 40));
            end
            return q;
        end
    endfunction

    function automatic query_t make_query(input int ax, ay, bx, by, cx, cy, dx, dy,
                                          input int px, py, r, input bit tan);
        query_t q;
        begin
            q = '{COORD_W'(ax), COORD_W'(ay), COORD_W'(bx), COORD_W'(by),
                  COORD_W'(cx), COORD_W'(cy), COORD_W'(dx), COORD_W'(dy),
                  COORD_W'(px), COORD_W'(py), RAD_W'(r), tan};
            return q;
        end
    endfunction

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tol_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || query_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            pending_q.push_back(random_query());
        drain();
    endtask

    initial
    begin
        tol_model = TOL_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 16, 1));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 40, 1));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 40, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 39, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 41, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 80, -30, 40, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, -30, 80, 40, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 200, 50, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 200, 60, 0));
        pending_q.push_back(make_query(0, 0, 0, 160, 160, 160, 160, 0, 200, 80, 50, 0));
        pending_q.push_back(make_query(0, 0, 0, 0, 160, 160, 0, 160, -20, -20, 40, 0));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 0, 1));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 161, 80, 0, 0));
        pending_q.push_back(make_query(-32768, -32768, 32767, -32768, 32767, 32767,
                                       -32768, 32767, 0, 0, 32767, 0));
        pending_q.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, 32767, 32767, 32767, 1));
        pending_q.push_back(make_query(32767, 32767, -32768, 32767, -32768, -32768,
                                       32767, -32768, 32767, -32768, 32767, 0));
        pending_q.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 32767, 1));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 0, 0));
        drain();
        run_random(500);
        write_tolerance(0);
        run_random(200);
        write_tolerance(255);
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 200, 80, 200, 1));
        pending_q.push_back(make_query(0, 0, 160, 0, 160, 160, 0, 160, 240, 80, 100, 0));
        run_random(250);
        send_idle_pct = 46;
        recv_idle_pct = 23;
        write_tolerance(8'($urandom_range(1, 254)));
        run_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 150; i++)
            pending_q.push_back(random_query());
        hold_cycles = 300;
        drain();
        write_tolerance(TOL_RESET);
        run_random(250);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
